### hdl/i2cs_pkg.sv
// Shared types and codes for the I2C master register sequencer.
// Depends on nothing; the core, queue, top level, checker and testbench refer to it by scoped names.
package i2cs_pkg;

  // Input word actions.
  typedef enum logic [2:0] {
    ACT_LOAD     = 3'd0,
    ACT_START_WR = 3'd1,
    ACT_START_RD = 3'd2,
    ACT_TX_READY = 3'd3,
    ACT_RX_BYTE  = 3'd4
  } action_e;

  // Commands handed to the byte-level bus engine.
  typedef enum logic [2:0] {
    CMD_NONE       = 3'd0,
    CMD_START_TX   = 3'd1,
    CMD_SEND       = 3'd2,
    CMD_RESTART_RX = 3'd3,
    CMD_STOP       = 3'd4
  } cmd_e;

  // Transaction modes.
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_REG    = 3'd1,
    MODE_SWITCH = 3'd2,
    MODE_DATA   = 3'd3,
    MODE_RECV   = 3'd4
  } mode_e;

  // One input word.
  typedef struct packed {
    logic [2:0] action;
    logic [6:0] slave_address;
    logic [7:0] register_address;
    logic [5:0] byte_count;
    logic [7:0] data_byte;
    logic [4:0] load_index;
  } item_t;

  // One result word.
  typedef struct packed {
    logic [2:0] bus_command;
    logic [6:0] target_address;
    logic [7:0] send_byte;
    logic       read_valid;
    logic [7:0] read_byte;
    logic [4:0] read_index;
    logic       transfer_done;
    logic [2:0] mode_now;
    logic       last;
  } res_t;

endpackage

### hdl/i2cs_if.sv
// Valid/ready channel interfaces for the input and result words.
// Depends on nothing; payload fields follow i2cs_pkg item_t and res_t.
interface i2cs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [6:0] slave_address;
  logic [7:0] register_address;
  logic [5:0] byte_count;
  logic [7:0] data_byte;
  logic [4:0] load_index;

  modport source (
    output valid, action, slave_address, register_address, byte_count,
           data_byte, load_index,
    input  ready
  );
  modport sink (
    input  valid, action, slave_address, register_address, byte_count,
           data_byte, load_index,
    output ready
  );
endinterface

interface i2cs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] bus_command;
  logic [6:0] target_address;
  logic [7:0] send_byte;
  logic       read_valid;
  logic [7:0] read_byte;
  logic [4:0] read_index;
  logic       transfer_done;
  logic [2:0] mode_now;
  logic       last;

  modport source (
    output valid, bus_command, target_address, send_byte, read_valid, read_byte,
           read_index, transfer_done, mode_now, last,
    input  ready
  );
  modport sink (
    input  valid, bus_command, target_address, send_byte, read_valid, read_byte,
           read_index, transfer_done, mode_now, last,
    output ready
  );
endinterface

### hdl/i2c_master_register_sequencer.sv
// A word is held in the input register until the result queue has room for its
// results, then decoded into that queue, whose head drives the output channel.
// Throughput: one input word per cycle while the queue has room and the output
// drains it; a word with two results takes both entries of the two-entry queue.
// Reset clears all control state; the transmit store reads as zero through
// per-entry valid bits, so no clearing pass is needed.
module i2c_master_register_sequencer #(
  parameter int BUF_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  i2cs_in_if.sink    in_i,
  i2cs_out_if.source out_o
);

  localparam int AW = $clog2(BUF_DEPTH);

  logic            in_vld_q;
  i2cs_pkg::item_t item_q;
  logic            fire;
  logic [1:0]      nres;
  logic [1:0]      room;
  i2cs_pkg::res_t  res0, res1, head;
  logic            ld_we;
  logic [AW-1:0]   ld_addr;
  logic [7:0]      ld_data;
  logic [AW-1:0]   rd_addr;
  logic [7:0]      tx_head;

  // Input register: refills whenever the held word is consumed.
  assign fire       = in_vld_q && (room >= nres);
  assign in_i.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q.action           <= in_i.action;
      item_q.slave_address    <= in_i.slave_address;
      item_q.register_address <= in_i.register_address;
      item_q.byte_count       <= in_i.byte_count;
      item_q.data_byte        <= in_i.data_byte;
      item_q.load_index       <= in_i.load_index;
    end
  end

  i2cs_core #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (item_q),
    .head_i    (tx_head),
    .nres_o    (nres),
    .res0_o    (res0),
    .res1_o    (res1),
    .ld_we_o   (ld_we),
    .ld_addr_o (ld_addr),
    .ld_data_o (ld_data),
    .rd_addr_o (rd_addr)
  );

  i2cs_txbuf #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_txbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (ld_we),
    .waddr_i (ld_addr),
    .wdata_i (ld_data),
    .raddr_i (rd_addr),
    .head_o  (tx_head)
  );

  i2cs_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fire),
    .npush_i (nres),
    .res0_i  (res0),
    .res1_i  (res1),
    .ready_i (out_o.ready),
    .valid_o (out_o.valid),
    .head_o  (head),
    .room_o  (room)
  );

  // Result word onto the output channel.
  assign out_o.bus_command    = head.bus_command;
  assign out_o.target_address = head.target_address;
  assign out_o.send_byte      = head.send_byte;
  assign out_o.read_valid     = head.read_valid;
  assign out_o.read_byte      = head.read_byte;
  assign out_o.read_index     = head.read_index;
  assign out_o.transfer_done  = head.transfer_done;
  assign out_o.mode_now       = head.mode_now;
  assign out_o.last           = head.last;

endmodule

### hdl/i2cs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module i2cs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old contents when the same address is written.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/i2cs_txbuf.sv
// Transmit byte store: RAM plus per-entry valid bits and a write bypass.
// The byte at the current send position is read ahead of its use, through a registered read.
// Depends on i2cs_ram.
module i2cs_txbuf #(
  parameter int BUF_DEPTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [$clog2(BUF_DEPTH)-1:0] waddr_i,
  input  logic [7:0]                   wdata_i,
  input  logic [$clog2(BUF_DEPTH)-1:0] raddr_i,
  output logic [7:0]                   head_o
);

  localparam int AW = $clog2(BUF_DEPTH);

  logic [BUF_DEPTH-1:0] vld_q;
  logic [AW-1:0]        raddr_q;
  logic                 byp_q;
  logic [7:0]           byp_data_q;
  logic [7:0]           ram_rdata;

  i2cs_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .waddr_i (waddr_i),
    .wdata_i (wdata_i),
    .raddr_i (raddr_i),
    .rdata_o (ram_rdata)
  );

  // Valid bits, read address and bypass flag track what the RAM holds.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      raddr_q <= '0;
      byp_q   <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      raddr_q <= raddr_i;
      byp_q   <= we_i && (waddr_i == raddr_i);
    end
  end

  // A write that collides with the read returns the new byte next cycle.
  always_ff @(posedge clk_i) begin
    byp_data_q <= wdata_i;
  end

  // Entries never written read as zero.
  assign head_o = !vld_q[raddr_q] ? 8'h00 : (byp_q ? byp_data_q : ram_rdata);

endmodule

### hdl/i2cs_core.sv
// Transaction state machine: decodes one word and forms its one or two results.
// Depends on i2cs_pkg.
module i2cs_core #(
  parameter int BUF_DEPTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  i2cs_pkg::item_t              item_i,
  input  logic [7:0]                   head_i,
  output logic [1:0]                   nres_o,
  output i2cs_pkg::res_t               res0_o,
  output i2cs_pkg::res_t               res1_o,
  output logic                         ld_we_o,
  output logic [$clog2(BUF_DEPTH)-1:0] ld_addr_o,
  output logic [7:0]                   ld_data_o,
  output logic [$clog2(BUF_DEPTH)-1:0] rd_addr_o
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam int CW = $clog2(BUF_DEPTH + 1);

  i2cs_pkg::mode_e mode_q, mode_d;
  logic [7:0]      reg_q, reg_d;
  logic [6:0]      slave_q, slave_d;
  logic [CW-1:0]   tx_rem_q, tx_rem_d;
  logic [CW-1:0]   rx_rem_q, rx_rem_d;
  logic [CW-1:0]   tx_pos_q, tx_pos_d;
  logic [CW-1:0]   rx_pos_q, rx_pos_d;
  logic [CW-1:0]   sat_count;
  logic [CW-1:0]   rx_rem_after;
  logic            ld_ok;

  // State registers advance only when the word is consumed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= i2cs_pkg::MODE_IDLE;
      reg_q    <= '0;
      slave_q  <= '0;
      tx_rem_q <= '0;
      rx_rem_q <= '0;
      tx_pos_q <= '0;
      rx_pos_q <= '0;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      reg_q    <= reg_d;
      slave_q  <= slave_d;
      tx_rem_q <= tx_rem_d;
      rx_rem_q <= rx_rem_d;
      tx_pos_q <= tx_pos_d;
      rx_pos_q <= rx_pos_d;
    end
  end

  // Byte count limited to the store depth.
  assign sat_count = (32'(item_i.byte_count) > BUF_DEPTH) ?
                     CW'(BUF_DEPTH) : CW'(item_i.byte_count);
  assign rx_rem_after = rx_rem_q - CW'(rx_rem_q != '0);
  assign ld_ok = 32'(item_i.load_index) < BUF_DEPTH;

  // Store write port and the look-ahead read address.
  assign ld_addr_o = AW'(item_i.load_index);
  assign ld_data_o = item_i.data_byte;
  assign rd_addr_o = fire_i ? tx_pos_d[AW-1:0] : tx_pos_q[AW-1:0];

  // Next state and results.
  always_comb begin
    mode_d   = mode_q;
    reg_d    = reg_q;
    slave_d  = slave_q;
    tx_rem_d = tx_rem_q;
    rx_rem_d = rx_rem_q;
    tx_pos_d = tx_pos_q;
    rx_pos_d = rx_pos_q;
    ld_we_o  = 1'b0;
    nres_o   = 2'd1;
    res0_o   = '0;
    res1_o   = '0;
    res0_o.bus_command = i2cs_pkg::CMD_NONE;
    res0_o.last        = 1'b1;
    res1_o.bus_command = i2cs_pkg::CMD_STOP;
    res1_o.last        = 1'b1;

    unique case (i2cs_pkg::action_e'(item_i.action))
      i2cs_pkg::ACT_LOAD: begin
        ld_we_o = fire_i && ld_ok;
      end
      i2cs_pkg::ACT_START_WR, i2cs_pkg::ACT_START_RD: begin
        // A start always aborts whatever is in flight.
        mode_d  = i2cs_pkg::MODE_REG;
        reg_d   = item_i.register_address;
        slave_d = item_i.slave_address;
        if (i2cs_pkg::action_e'(item_i.action) == i2cs_pkg::ACT_START_WR) begin
          tx_rem_d = sat_count;
          rx_rem_d = '0;
        end else begin
          rx_rem_d = sat_count;
          tx_rem_d = '0;
        end
        tx_pos_d = '0;
        rx_pos_d = '0;
        res0_o.bus_command    = i2cs_pkg::CMD_START_TX;
        res0_o.target_address = item_i.slave_address;
      end
      i2cs_pkg::ACT_TX_READY: begin
        unique case (mode_q)
          i2cs_pkg::MODE_REG: begin
            mode_d = (rx_rem_q != '0) ? i2cs_pkg::MODE_SWITCH : i2cs_pkg::MODE_DATA;
            res0_o.bus_command = i2cs_pkg::CMD_SEND;
            res0_o.send_byte   = reg_q;
          end
          i2cs_pkg::MODE_SWITCH: begin
            mode_d = i2cs_pkg::MODE_RECV;
            res0_o.bus_command    = i2cs_pkg::CMD_RESTART_RX;
            res0_o.target_address = slave_q;
            // A single-byte read asks for the stop right behind the restart.
            if (rx_rem_q == CW'(1)) begin
              res0_o.last = 1'b0;
              nres_o      = 2'd2;
            end
          end
          i2cs_pkg::MODE_DATA: begin
            if (tx_rem_q != '0 && 32'(tx_pos_q) < BUF_DEPTH) begin
              tx_pos_d = tx_pos_q + CW'(1);
              tx_rem_d = tx_rem_q - CW'(1);
              res0_o.bus_command = i2cs_pkg::CMD_SEND;
              res0_o.send_byte   = head_i;
            end else begin
              tx_rem_d = '0;
              mode_d   = i2cs_pkg::MODE_IDLE;
              res0_o.bus_command   = i2cs_pkg::CMD_STOP;
              res0_o.transfer_done = 1'b1;
            end
          end
          i2cs_pkg::MODE_IDLE, i2cs_pkg::MODE_RECV: begin
            res0_o.bus_command = i2cs_pkg::CMD_NONE;
          end
          default: begin
            res0_o.bus_command = i2cs_pkg::CMD_NONE;
          end
        endcase
      end
      i2cs_pkg::ACT_RX_BYTE: begin
        if (mode_q == i2cs_pkg::MODE_RECV) begin
          if (rx_rem_q != '0) begin
            res0_o.read_valid = 1'b1;
            res0_o.read_byte  = item_i.data_byte;
            res0_o.read_index = 5'(rx_pos_q);
            rx_pos_d = rx_pos_q + CW'(1);
          end
          rx_rem_d = rx_rem_after;
          if (rx_rem_after == CW'(1)) begin
            res0_o.bus_command = i2cs_pkg::CMD_STOP;
          end else if (rx_rem_after == '0) begin
            mode_d = i2cs_pkg::MODE_IDLE;
            res0_o.transfer_done = 1'b1;
          end
        end
      end
      default: begin
        res0_o.bus_command = i2cs_pkg::CMD_NONE;
      end
    endcase

    res0_o.mode_now = mode_d;
    res1_o.mode_now = mode_d;
  end

endmodule

### hdl/i2cs_outq.sv
// Two-entry result queue; entry zero drives the output channel.
// Depends on i2cs_pkg.
module i2cs_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  logic [1:0]     npush_i,
  input  i2cs_pkg::res_t res0_i,
  input  i2cs_pkg::res_t res1_i,
  input  logic           ready_i,
  output logic           valid_o,
  output i2cs_pkg::res_t head_o,
  output logic [1:0]     room_o
);

  logic [1:0]     cnt_q, cnt_d, base;
  i2cs_pkg::res_t ent0_q, ent1_q, ent0_d, ent1_d;
  logic           pop;

  assign valid_o = cnt_q != 2'd0;
  assign head_o  = ent0_q;
  assign pop     = valid_o && ready_i;
  assign base    = cnt_q - {1'b0, pop};
  // Room counts the slot freed by this cycle's pop.
  assign room_o  = 2'd2 - base;

  // Shift on pop, then append new words behind what remains.
  always_comb begin
    ent0_d = pop ? ent1_q : ent0_q;
    ent1_d = ent1_q;
    cnt_d  = base;
    if (push_i) begin
      cnt_d = base + npush_i;
      unique case (base)
        2'd0: begin
          ent0_d = res0_i;
          ent1_d = res1_i;
        end
        2'd1: begin
          ent1_d = res0_i;
        end
        default: begin
          ent1_d = ent1_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent0_q <= ent0_d;
    ent1_q <= ent1_d;
  end

endmodule

### hdl/i2cs_checker.sv
// Port-level checks on the result channel of the sequencer, and their bind.
// Depends on i2cs_pkg and i2c_master_register_sequencer.
module i2cs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] bus_command_i,
  input logic       read_valid_i,
  input logic       transfer_done_i,
  input logic [2:0] mode_now_i,
  input logic       last_i
);

  // A finished transfer always leaves the sequencer idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && transfer_done_i |-> mode_now_i == i2cs_pkg::MODE_IDLE)
    else $error("transfer_done without idle mode");

  // Received bytes are only stored in receive mode, or with the final byte, which returns to idle.
  a_read_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && read_valid_i |->
      (mode_now_i == i2cs_pkg::MODE_RECV || mode_now_i == i2cs_pkg::MODE_IDLE))
    else $error("read byte stored outside receive");

  // Only the restart of a single-byte read is followed by a second word.
  a_first_of_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_i |->
      bus_command_i == i2cs_pkg::CMD_RESTART_RX && mode_now_i == i2cs_pkg::MODE_RECV)
    else $error("non-final word is not a restart");

  // The stop of a pair is ready right after the restart is taken.
  a_pair_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=>
      out_valid_i && bus_command_i == i2cs_pkg::CMD_STOP && last_i)
    else $error("stop does not follow restart");

endmodule

bind i2c_master_register_sequencer i2cs_checker u_i2cs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .bus_command_i   (out_o.bus_command),
  .read_valid_i    (out_o.read_valid),
  .transfer_done_i (out_o.transfer_done),
  .mode_now_i      (out_o.mode_now),
  .last_i          (out_o.last)
);

### tb/i2c_master_register_sequencer_tb.sv
// Self-checking testbench for the I2C master register sequencer.
// Needs i2cs_pkg, the i2cs_in_if and i2cs_out_if channels, and the sequencer itself.
`timescale 1ns / 1ps

module i2c_master_register_sequencer_tb;

  localparam int BUF_DEPTH = 32;
  localparam int HOLD_START = 150;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_WORDS = 400;

  // Action codes that the block does not define; it must ignore them.
  localparam logic [2:0] ACT_UNDEF_LO = 3'd5;
  localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

  // One stimulus row; a typed row carries its own single result.
  typedef struct {
    i2cs_pkg::item_t word;
    bit              typed;
    i2cs_pkg::res_t  res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  i2cs_in_if  in_if ();
  i2cs_out_if out_if ();

  i2c_master_register_sequencer #(
    .BUF_DEPTH(BUF_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  stim_row_t      stim_rows[$];
  i2cs_pkg::res_t results_due[$];
  int             errors = 0;

  // Shadow copy of the sequencer state.
  i2cs_pkg::mode_e seq_mode = i2cs_pkg::MODE_IDLE;
  logic [7:0] seq_register = '0;
  logic [6:0] seq_slave = '0;
  logic [5:0] tx_left = '0;
  logic [5:0] rx_left = '0;
  logic [5:0] tx_pos = '0;
  logic [5:0] rx_pos = '0;
  logic [7:0] tx_bytes [BUF_DEPTH];

  // Clock and reset.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic i2cs_pkg::res_t mk_res(logic [2:0] cmd, logic [6:0] addr,
                                            logic [7:0] sb, logic rv, logic [7:0] rb,
                                            logic [4:0] ri, logic done, logic [2:0] md,
                                            logic lst);
    i2cs_pkg::res_t r;
    r.bus_command    = cmd;
    r.target_address = addr;
    r.send_byte      = sb;
    r.read_valid     = rv;
    r.read_byte      = rb;
    r.read_index     = ri;
    r.transfer_done  = done;
    r.mode_now       = md;
    r.last           = lst;
    return r;
  endfunction

  function automatic i2cs_pkg::item_t make_word(logic [2:0] act, logic [6:0] slave,
                                                logic [7:0] regb, logic [5:0] cnt,
                                                logic [7:0] data, logic [4:0] idx);
    i2cs_pkg::item_t w;
    w.action           = act;
    w.slave_address    = slave;
    w.register_address = regb;
    w.byte_count       = cnt;
    w.data_byte        = data;
    w.load_index       = idx;
    return w;
  endfunction

  // A word of the given action with every other field random.
  function automatic i2cs_pkg::item_t random_word(logic [2:0] act);
    return make_word(act, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                     6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)),
                     5'($urandom_range(0, 31)));
  endfunction

  function automatic void add_row(i2cs_pkg::item_t w, bit typed, i2cs_pkg::res_t r);
    stim_row_t row;
    row.word  = w;
    row.typed = typed;
    row.res   = r;
    stim_rows.push_back(row);
  endfunction

  // Result words carry the mode as it stands after the update.
  function automatic void due(logic [2:0] cmd, logic [6:0] addr, logic [7:0] sb,
                              logic rv, logic [7:0] rb, logic [4:0] ri,
                              logic done, logic lst);
    results_due.push_back(mk_res(cmd, addr, sb, rv, rb, ri, done, seq_mode, lst));
  endfunction

  // Advances the shadow state by one accepted word and queues its bus results.
  function automatic void next_bus_results(i2cs_pkg::item_t w);
    logic [5:0] cnt;
    cnt = (w.byte_count > BUF_DEPTH) ? 6'(BUF_DEPTH) : w.byte_count;
    case (w.action)
      i2cs_pkg::ACT_LOAD: begin
        if (w.load_index < BUF_DEPTH) tx_bytes[w.load_index] = w.data_byte;
        due(i2cs_pkg::CMD_NONE, '0, '0, 1'b0, '0, '0, 1'b0, 1'b1);
      end
      i2cs_pkg::ACT_START_WR, i2cs_pkg::ACT_START_RD: begin
        // A start always abandons whatever transaction is in flight.
        seq_mode     = i2cs_pkg::MODE_REG;
        seq_register = w.register_address;
        seq_slave    = w.slave_address;
        tx_left      = (w.action == i2cs_pkg::ACT_START_WR) ? cnt : 6'd0;
        rx_left      = (w.action == i2cs_pkg::ACT_START_RD) ? cnt : 6'd0;
        tx_pos       = '0;
        rx_pos       = '0;
        due(i2cs_pkg::CMD_START_TX, seq_slave, '0, 1'b0, '0, '0, 1'b0, 1'b1);
      end
      i2cs_pkg::ACT_TX_READY: begin
        case (seq_mode)
          i2cs_pkg::MODE_REG: begin
            seq_mode = (rx_left != 0) ? i2cs_pkg::MODE_SWITCH : i2cs_pkg::MODE_DATA;
            due(i2cs_pkg::CMD_SEND, '0, seq_register, 1'b0, '0, '0, 1'b0, 1'b1);
          end
          i2cs_pkg::MODE_SWITCH: begin
            // A single-byte read asks for the stop right with the restart.
            seq_mode = i2cs_pkg::MODE_RECV;
            if (rx_left == 1) begin
              due(i2cs_pkg::CMD_RESTART_RX, seq_slave, '0, 1'b0, '0, '0, 1'b0, 1'b0);
              due(i2cs_pkg::CMD_STOP, '0, '0, 1'b0, '0, '0, 1'b0, 1'b1);
            end else begin
              due(i2cs_pkg::CMD_RESTART_RX, seq_slave, '0, 1'b0, '0, '0, 1'b0, 1'b1);
            end
          end
          i2cs_pkg::MODE_DATA: begin
            if (tx_left != 0 && tx_pos < BUF_DEPTH) begin
              due(i2cs_pkg::CMD_SEND, '0, tx_bytes[tx_pos[4:0]], 1'b0, '0, '0, 1'b0, 1'b1);
              tx_pos  = tx_pos + 1;
              tx_left = tx_left - 1;
            end else begin
              tx_left  = '0;
              seq_mode = i2cs_pkg::MODE_IDLE;
              due(i2cs_pkg::CMD_STOP, '0, '0, 1'b0, '0, '0, 1'b1, 1'b1);
            end
          end
          default: due(i2cs_pkg::CMD_NONE, '0, '0, 1'b0, '0, '0, 1'b0, 1'b1);
        endcase
      end
      i2cs_pkg::ACT_RX_BYTE: begin
        if (seq_mode == i2cs_pkg::MODE_RECV) begin
          logic       rv;
          logic [4:0] ri;
          logic [2:0] cmd;
          logic       done;
          rv   = 1'b0;
          ri   = '0;
          cmd  = i2cs_pkg::CMD_NONE;
          done = 1'b0;
          if (rx_left != 0) begin
            rv      = 1'b1;
            ri      = rx_pos[4:0];
            rx_pos  = rx_pos + 1;
            rx_left = rx_left - 1;
          end
          if (rx_left == 1) begin
            cmd = i2cs_pkg::CMD_STOP;
          end else if (rx_left == 0) begin
            seq_mode = i2cs_pkg::MODE_IDLE;
            done     = 1'b1;
          end
          due(cmd, '0, '0, rv, rv ? w.data_byte : 8'h00, ri, done, 1'b1);
        end else begin
          due(i2cs_pkg::CMD_NONE, '0, '0, 1'b0, '0, '0, 1'b0, 1'b1);
        end
      end
      default: due(i2cs_pkg::CMD_NONE, '0, '0, 1'b0, '0, '0, 1'b0, 1'b1);
    endcase
  endfunction

  // Random traffic: loads, mostly complete transactions with random content, some aborted
  // ones, and some noise. Noise does not count toward the target.
  function automatic void add_random_traffic(int target);
    int              useful;
    int              kind;
    int              n;
    logic [5:0]      cnt;
    i2cs_pkg::item_t w;
    useful = 0;
    while (useful < target) begin
      kind = $urandom_range(0, 9);
      cnt  = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                         : 6'($urandom_range(0, 5));
      n    = ((cnt > BUF_DEPTH) ? BUF_DEPTH : int'(cnt));
      case (kind)
        0, 1: begin
          n = $urandom_range(1, 4);
          repeat (n) add_row(random_word(i2cs_pkg::ACT_LOAD), 1'b0, '0);
          useful += n;
        end
        2, 3, 4: begin
          w = random_word(i2cs_pkg::ACT_START_WR);
          w.byte_count = cnt;
          add_row(w, 1'b0, '0);
          repeat (n + 2) begin
            if ($urandom_range(0, 7) == 0) begin
              add_row(random_word(i2cs_pkg::ACT_LOAD), 1'b0, '0);
            end
            add_row(random_word(i2cs_pkg::ACT_TX_READY), 1'b0, '0);
          end
          useful += n + 3;
        end
        5, 6, 7: begin
          w = random_word(i2cs_pkg::ACT_START_RD);
          w.byte_count = cnt;
          add_row(w, 1'b0, '0);
          add_row(random_word(i2cs_pkg::ACT_TX_READY), 1'b0, '0);
          add_row(random_word(i2cs_pkg::ACT_TX_READY), 1'b0, '0);
          repeat (n) add_row(random_word(i2cs_pkg::ACT_RX_BYTE), 1'b0, '0);
          useful += n + 3;
        end
        8: begin
          // Transaction cut short; the next start aborts it.
          w = random_word($urandom_range(0, 1) ? i2cs_pkg::ACT_START_WR
                                               : i2cs_pkg::ACT_START_RD);
          w.byte_count = cnt;
          add_row(w, 1'b0, '0);
          n = $urandom_range(0, 4);
          repeat (n) begin
            add_row(random_word($urandom_range(0, 1) ? i2cs_pkg::ACT_TX_READY
                                                     : i2cs_pkg::ACT_RX_BYTE),
                    1'b0, '0);
          end
          useful += n + 1;
        end
        default: begin
          n = $urandom_range(1, 3);
          repeat (n) add_row(random_word(3'($urandom_range(0, 7))), 1'b0, '0);
        end
      endcase
    end
  endfunction

  // Directed rows, then the random traffic.
  function automatic void build_stimulus();
    // Ignored words right after reset.
    add_row(make_word(i2cs_pkg::ACT_TX_READY, 7'h7F, 8'hFF, 6'h3F, 8'hFF, 5'h1F), 1'b1,
            mk_res(i2cs_pkg::CMD_NONE, '0, '0, 1'b0, '0, '0, 1'b0,
                   i2cs_pkg::MODE_IDLE, 1'b1));
    add_row(make_word(i2cs_pkg::ACT_RX_BYTE, 7'h00, 8'h00, 6'h00, 8'hFF, 5'h00), 1'b1,
            mk_res(i2cs_pkg::CMD_NONE, '0, '0, 1'b0, '0, '0, 1'b0,
                   i2cs_pkg::MODE_IDLE, 1'b1));
    add_row(make_word(ACT_UNDEF_LO, 7'h2A, 8'h55, 6'h15, 8'hAA, 5'h0A), 1'b1,
            mk_res(i2cs_pkg::CMD_NONE, '0, '0, 1'b0, '0, '0, 1'b0,
                   i2cs_pkg::MODE_IDLE, 1'b1));
    add_row(make_word(ACT_UNDEF_HI, 7'h55, 8'hAA, 6'h2A, 8'h55, 5'h15), 1'b1,
            mk_res(i2cs_pkg::CMD_NONE, '0, '0, 1'b0, '0, '0, 1'b0,
                   i2cs_pkg::MODE_IDLE, 1'b1));
    // Loads at both ends of the store.
    add_row(make_word(i2cs_pkg::ACT_LOAD, 7'h00, 8'h00, 6'h00, 8'hFF, 5'h00), 1'b1,
            mk_res(i2cs_pkg::CMD_NONE, '0, '0, 1'b0, '0, '0, 1'b0,
                   i2cs_pkg::MODE_IDLE, 1'b1));
    add_row(make_word(i2cs_pkg::ACT_LOAD, 7'h00, 8'h00, 6'h00, 8'hA5, 5'h1F), 1'b1,
            mk_res(i2cs_pkg::CMD_NONE, '0, '0, 1'b0, '0, '0, 1'b0,
                   i2cs_pkg::MODE_IDLE, 1'b1));
    // Write with a count above the depth; it saturates.
    add_row(make_word(i2cs_pkg::ACT_START_WR, 7'h7F, 8'hFF, 6'h3F, 8'h00, 5'h00), 1'b1,
            mk_res(i2cs_pkg::CMD_START_TX, 7'h7F, '0, 1'b0, '0, '0, 1'b0,
                   i2cs_pkg::MODE_REG, 1'b1));
    add_row(make_word(i2cs_pkg::ACT_TX_READY, 7'h00, 8'h00, 6'h00, 8'h00, 5'h00), 1'b0, '0);
    add_row(make_word(i2cs_pkg::ACT_TX_READY, 7'h00, 8'h00, 6'h00, 8'h00, 5'h00), 1'b0, '0);
    // Single-byte read starting while the write is busy.
    add_row(make_word(i2cs_pkg::ACT_START_RD, 7'h00, 8'h00, 6'h01, 8'h00, 5'h00), 1'b1,
            mk_res(i2cs_pkg::CMD_START_TX, 7'h00, '0, 1'b0, '0, '0, 1'b0,
                   i2cs_pkg::MODE_REG, 1'b1));
    add_row(make_word(i2cs_pkg::ACT_TX_READY, 7'h00, 8'h00, 6'h00, 8'h00, 5'h00), 1'b0, '0);
    add_row(make_word(i2cs_pkg::ACT_LOAD, 7'h00, 8'h00, 6'h00, 8'h5A, 5'h01), 1'b0, '0);
    add_row(make_word(i2cs_pkg::ACT_TX_READY, 7'h00, 8'h00, 6'h00, 8'h00, 5'h00), 1'b0, '0);
    add_row(make_word(i2cs_pkg::ACT_RX_BYTE, 7'h00, 8'h00, 6'h00, 8'hFF, 5'h00), 1'b0, '0);
    // Read of zero bytes ends like an empty write.
    add_row(make_word(i2cs_pkg::ACT_START_RD, 7'h55, 8'h3C, 6'h00, 8'h00, 5'h00), 1'b0, '0);
    add_row(make_word(i2cs_pkg::ACT_TX_READY, 7'h00, 8'h00, 6'h00, 8'h00, 5'h00), 1'b0, '0);
    add_row(make_word(i2cs_pkg::ACT_TX_READY, 7'h00, 8'h00, 6'h00, 8'h00, 5'h00), 1'b0, '0);
    // Three-byte read, with a transmitter ready during reception.
    add_row(make_word(i2cs_pkg::ACT_START_RD, 7'h2A, 8'hC3, 6'h03, 8'h00, 5'h00), 1'b0, '0);
    add_row(make_word(i2cs_pkg::ACT_TX_READY, 7'h00, 8'h00, 6'h00, 8'h00, 5'h00), 1'b0, '0);
    add_row(make_word(i2cs_pkg::ACT_TX_READY, 7'h00, 8'h00, 6'h00, 8'h00, 5'h00), 1'b0, '0);
    add_row(make_word(i2cs_pkg::ACT_RX_BYTE, 7'h00, 8'h00, 6'h00, 8'h00, 5'h00), 1'b0, '0);
    add_row(make_word(i2cs_pkg::ACT_TX_READY, 7'h00, 8'h00, 6'h00, 8'h00, 5'h00), 1'b0, '0);
    add_row(make_word(i2cs_pkg::ACT_RX_BYTE, 7'h00, 8'h00, 6'h00, 8'h81, 5'h00), 1'b0, '0);
    add_row(make_word(i2cs_pkg::ACT_RX_BYTE, 7'h00, 8'h00, 6'h00, 8'h7E, 5'h00), 1'b0, '0);
    add_random_traffic(RANDOM_WORDS);
  endfunction

  // Sender: bursts of random length separated by random gaps.
  initial begin : sender
    stim_row_t row;
    int        burst_left;
    int        gap;
    in_if.valid            = 1'b0;
    in_if.action           = '0;
    in_if.slave_address    = '0;
    in_if.register_address = '0;
    in_if.byte_count       = '0;
    in_if.data_byte        = '0;
    in_if.load_index       = '0;
    foreach (tx_bytes[i]) tx_bytes[i] = '0;
    build_stimulus();
    burst_left = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    while (stim_rows.size() != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_if.valid = 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      row = stim_rows.pop_front();
      in_if.action           = row.word.action;
      in_if.slave_address    = row.word.slave_address;
      in_if.register_address = row.word.register_address;
      in_if.byte_count       = row.word.byte_count;
      in_if.data_byte        = row.word.data_byte;
      in_if.load_index       = row.word.load_index;
      in_if.valid            = 1'b1;
      @(posedge clk_i);
      while (!in_if.ready) @(posedge clk_i);
      // Word accepted at this edge.
      next_bus_results(row.word);
      if (row.typed) begin
        results_due.delete(results_due.size() - 1);
        results_due.push_back(row.res);
      end
      burst_left--;
      @(negedge clk_i);
    end
    in_if.valid = 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Receiver: a stall pattern chosen at random and changed periodically, plus one long hold-off
  // early in the random traffic so that the block backs up into its input.
  initial begin : receiver
    int cyc;
    int style;
    out_if.ready = 1'b0;
    cyc = 0;
    style = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (cyc % 48 == 0) style = $urandom_range(0, 3);
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) begin
        out_if.ready = 1'b0;
      end else begin
        case (style)
          0:       out_if.ready = 1'b1;
          1:       out_if.ready = (cyc % 5 != 2) && (cyc % 5 != 3);
          2:       out_if.ready = 1'($urandom_range(0, 1));
          default: out_if.ready = ($urandom_range(0, 7) != 0);
        endcase
      end
      cyc++;
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    i2cs_pkg::res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (results_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, got cmd %0d mode %0d",
                 $time, out_if.bus_command, out_if.mode_now);
      end else begin
        want = results_due.pop_front();
        check_field("bus_command", want.bus_command, out_if.bus_command);
        check_field("target_address", want.target_address, out_if.target_address);
        check_field("send_byte", want.send_byte, out_if.send_byte);
        check_field("read_valid", want.read_valid, out_if.read_valid);
        check_field("read_byte", want.read_byte, out_if.read_byte);
        check_field("read_index", want.read_index, out_if.read_index);
        check_field("transfer_done", want.transfer_done, out_if.transfer_done);
        check_field("mode_now", want.mode_now, out_if.mode_now);
        check_field("last", want.last, out_if.last);
      end
    end
  end

endmodule
